/* sv/lidar_point_to_pixel_projection_assert.svh */
// assertion macros shared by the rtl
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_ASSERT_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_ASSERT_SVH

// condition must never hold
`define LPP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define LPP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpp_pkg.sv */
package lpp_pkg;

    localparam int PW = 20;
    localparam int RW = 20;
    localparam int TW = 21;
    localparam int FRAC = 18;
    localparam int PRW = PW + RW;
    localparam int CW = 43;
    localparam int DW = CW - 1;
    localparam int NW = DW + 16;
    localparam int QW = 30;
    localparam int HW = 17;
    localparam int DMW = 20;
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW = 2;

    localparam logic signed [CW-1:0] DEPTH_MIN = CW'(64'd1000 << FRAC);
    localparam logic [DMW-1:0] DEPTH_MAX = {DMW{1'b1}};

    typedef enum logic [2:0] {
        CFG_ROT0,
        CFG_ROT1,
        CFG_ROT2,
        CFG_TRANS,
        CFG_FOCAL,
        CFG_PRINC,
        CFG_IMG_W,
        CFG_IMG_H
    } t_cfg_idx;

    typedef struct packed {
        logic [62:0] rot0;
        logic [62:0] rot1;
        logic [62:0] rot2;
        logic [62:0] translation;
        logic [63:0] focal;
        logic [63:0] principal;
        logic [12:0] img_w;
        logic [12:0] img_h;
    } t_cfg;

    typedef struct packed {
        logic                 ok;
        logic signed [CW-1:0] cam_x;
        logic signed [CW-1:0] cam_y;
        logic [DW-1:0]        cam_z;
        logic [DMW-1:0]       dmm;
        logic [HW-1:0]        lo_x;
        logic [HW-1:0]        hi_x;
        logic [HW-1:0]        lo_y;
        logic [HW-1:0]        hi_y;
    } t_mid;

endpackage

/* sv/lpp_front.sv */
module lpp_front #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpp_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic signed [19:0]   i_point_x,
    input  logic signed [19:0]   i_point_y,
    input  logic signed [19:0]   i_point_z,
    input  logic                 i_use_roi,
    input  logic [11:0]          i_box_left,
    input  logic [11:0]          i_box_top,
    input  logic [12:0]          i_box_width,
    input  logic [12:0]          i_box_height,
    output logic                 o_valid,
    output lpp_pkg::t_mid        o_mid
);
    import lpp_pkg::*;

    localparam logic [HW-1:0] LIMIT = {{(HW-1){1'b0}}, 1'b1} << PIXEL_BITS;

    logic signed [PW-1:0]  w_p [3];
    logic [62:0]           w_rows [3];
    logic signed [RW-1:0]  w_rot [3][3];
    logic [HW-1:0]         w_lo_x, w_lo_y, w_hi_x, w_hi_y;

    logic                  r_v1, r_xpos;
    logic signed [PRW-1:0] r_prod [3][3];
    logic signed [TW-1:0]  r_t [3];
    logic [HW-1:0]         r_lo_x, r_lo_y, r_hi_x, r_hi_y;

    logic signed [CW-1:0]  w_cam [3];
    logic [CW-FRAC-2:0]    w_dmm_full;
    t_mid                  n_mid;
    logic                  r_v2;
    t_mid                  r_mid;

    always_comb begin
        w_p[0] = i_point_x;
        w_p[1] = i_point_y;
        w_p[2] = i_point_z;
        w_rows[0] = i_cfg.rot0;
        w_rows[1] = i_cfg.rot1;
        w_rows[2] = i_cfg.rot2;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                w_rot[j][i] = w_rows[j][RW*i +: RW];
            end
        end
    end

    // accepted area, clamped to what the pixel ports can carry
    always_comb begin
        if (i_use_roi) begin
            w_lo_x = HW'(i_box_left);
            w_lo_y = HW'(i_box_top);
            w_hi_x = HW'(i_box_left) + HW'(i_box_width);
            w_hi_y = HW'(i_box_top) + HW'(i_box_height);
        end else begin
            w_lo_x = '0;
            w_lo_y = '0;
            w_hi_x = HW'(i_cfg.img_w);
            w_hi_y = HW'(i_cfg.img_h);
        end
        if (w_hi_x > LIMIT) begin
            w_hi_x = LIMIT;
        end
        if (w_hi_y > LIMIT) begin
            w_hi_y = LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xpos <= (i_point_x > 0);
        for (int i = 0; i < 3; i++) begin
            r_t[i] <= i_cfg.translation[TW*i +: TW];
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= w_p[j] * w_rot[j][i];
            end
        end
        r_lo_x <= w_lo_x;
        r_lo_y <= w_lo_y;
        r_hi_x <= w_hi_x;
        r_hi_y <= w_hi_y;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cam[i] = {{(CW-TW-FRAC){r_t[i][TW-1]}}, r_t[i], {FRAC{1'b0}}};
            for (int j = 0; j < 3; j++) begin
                w_cam[i] = w_cam[i] + {{(CW-PRW){r_prod[i][j][PRW-1]}}, r_prod[i][j]};
            end
        end
        w_dmm_full = w_cam[2][CW-2:FRAC];
        n_mid.ok = r_xpos && (w_cam[2] > DEPTH_MIN);
        n_mid.cam_x = w_cam[0];
        n_mid.cam_y = w_cam[1];
        n_mid.cam_z = w_cam[2][DW-1:0];
        if (w_dmm_full > (CW-FRAC-1)'(DEPTH_MAX)) begin
            n_mid.dmm = DEPTH_MAX;
        end else begin
            n_mid.dmm = w_dmm_full[DMW-1:0];
        end
        n_mid.lo_x = r_lo_x;
        n_mid.hi_x = r_hi_x;
        n_mid.lo_y = r_lo_y;
        n_mid.hi_y = r_hi_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    assign o_valid = r_v2;
    assign o_mid = r_mid;

endmodule

/* sv/lpp_fifo.sv */
module lpp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpp_pkg::t_mid i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output lpp_pkg::t_mid o_data
);
    import lpp_pkg::*;

    `include "lidar_point_to_pixel_projection_assert.svh"

    t_mid             r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0] r_wr, r_rd;
    logic [MQ_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];

    `LPP_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n,
        i_push && !i_pop && (r_cnt == (MQ_AW+1)'(MQ_DEPTH)), "queue overflow")
    `LPP_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "queue underflow")
    `LPP_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop,
        r_cnt == $past(r_cnt) + 1'b1, "queue count did not follow push")

endmodule

/* sv/lpp_div.sv */
module lpp_div (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [lpp_pkg::NW-1:0]     i_num,
    input  logic [lpp_pkg::DW-1:0]     i_den,
    output logic [lpp_pkg::QW-1:0]     o_quot
);
    import lpp_pkg::*;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];

    // preloaded remainder is below the divisor since the quotient fits QW bits
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= {{(DW-(NW-QW)){1'b0}}, i_num[NW-1:QW]};
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_q[0] <= '0;
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_q;

        always_comb begin
            w_trial = {r_rem[s-1], r_low[s-1][QW-s]};
            w_ge = (w_trial >= {1'b0, r_den[s-1]});
            w_q = r_q[s-1];
            if (w_ge) begin
                w_rem = DW'(w_trial - {1'b0, r_den[s-1]});
                w_q[QW-s] = 1'b1;
            end else begin
                w_rem = w_trial[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s] <= w_rem;
                r_low[s] <= r_low[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s] <= w_q;
            end
        end
    end

    assign o_quot = r_q[QW];

endmodule

/* sv/lpp_back.sv */
module lpp_back #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpp_pkg::t_cfg         i_cfg,
    input  logic                  i_mq_empty,
    input  lpp_pkg::t_mid         i_mq_data,
    output logic                  o_mq_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_valid_res,
    output logic [PIXEL_BITS-1:0] o_pixel_x,
    output logic [PIXEL_BITS-1:0] o_pixel_y,
    output logic [19:0]           o_depth
);
    import lpp_pkg::*;

    localparam int MW = 33 + QW + 1;
    localparam int SW = MW + 2;
    localparam int PXW = SW - 32;

    typedef struct packed {
        logic           ok;
        logic           sx;
        logic           sy;
        logic [DMW-1:0] dmm;
        logic [HW-1:0]  lo_x;
        logic [HW-1:0]  hi_x;
        logic [HW-1:0]  lo_y;
        logic [HW-1:0]  hi_y;
    } t_side;

    logic                 w_ce;
    logic [DW-1:0]        w_mag_x, w_mag_y;
    logic [QW-1:0]        w_qx, w_qy;
    t_side                w_side_in;

    logic                 r_sv [QW+1];
    t_side                r_sd [QW+1];

    logic signed [QW:0]   w_rx, w_ry;
    logic                 r_mv;
    t_side                r_ms;
    logic signed [MW-1:0] r_prod_x, r_prod_y;

    logic signed [SW-1:0] w_num_x, w_num_y;
    logic signed [PXW-1:0] w_px, w_py;
    logic                 w_in;
    logic                 r_out_v, r_res_v;
    logic [PIXEL_BITS-1:0] r_pix_x, r_pix_y;
    logic [DMW-1:0]       r_depth;

    assign w_ce = !r_out_v || pop;
    assign o_mq_pop = w_ce && !i_mq_empty;

    always_comb begin
        w_mag_x = i_mq_data.cam_x[CW-1] ? DW'(-i_mq_data.cam_x) : i_mq_data.cam_x[DW-1:0];
        w_mag_y = i_mq_data.cam_y[CW-1] ? DW'(-i_mq_data.cam_y) : i_mq_data.cam_y[DW-1:0];
        w_side_in.ok = i_mq_data.ok;
        w_side_in.sx = i_mq_data.cam_x[CW-1];
        w_side_in.sy = i_mq_data.cam_y[CW-1];
        w_side_in.dmm = i_mq_data.dmm;
        w_side_in.lo_x = i_mq_data.lo_x;
        w_side_in.hi_x = i_mq_data.hi_x;
        w_side_in.lo_y = i_mq_data.lo_y;
        w_side_in.hi_y = i_mq_data.hi_y;
    end

    lpp_div u_div_x (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_num  ({w_mag_x, 16'b0}),
        .i_den  (i_mq_data.cam_z),
        .o_quot (w_qx)
    );

    lpp_div u_div_y (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_num  ({w_mag_y, 16'b0}),
        .i_den  (i_mq_data.cam_z),
        .o_quot (w_qy)
    );

    // side data rides along with the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (w_ce) begin
            r_sv[0] <= !i_mq_empty;
            for (int s = 1; s <= QW; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sd[0] <= w_side_in;
            for (int s = 1; s <= QW; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // quotient truncates toward zero
    always_comb begin
        w_rx = r_sd[QW].sx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
        w_ry = r_sd[QW].sy ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_ce) begin
            r_mv <= r_sv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ms <= r_sd[QW];
            r_prod_x <= $signed({1'b0, i_cfg.focal[31:0]}) * w_rx;
            r_prod_y <= $signed({1'b0, i_cfg.focal[63:32]}) * w_ry;
        end
    end

    // principal point and half, then floor to whole pixels
    always_comb begin
        w_num_x = {{(SW-MW){r_prod_x[MW-1]}}, r_prod_x}
                + $signed({{(SW-48){1'b0}}, i_cfg.principal[31:0], 16'b0})
                + $signed(SW'(64'h8000_0000));
        w_num_y = {{(SW-MW){r_prod_y[MW-1]}}, r_prod_y}
                + $signed({{(SW-48){1'b0}}, i_cfg.principal[63:32], 16'b0})
                + $signed(SW'(64'h8000_0000));
        w_px = w_num_x[SW-1:32];
        w_py = w_num_y[SW-1:32];
        w_in = r_ms.ok
            && (w_px >= $signed({{(PXW-HW){1'b0}}, r_ms.lo_x}))
            && (w_px <  $signed({{(PXW-HW){1'b0}}, r_ms.hi_x}))
            && (w_py >= $signed({{(PXW-HW){1'b0}}, r_ms.lo_y}))
            && (w_py <  $signed({{(PXW-HW){1'b0}}, r_ms.hi_y}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_ce) begin
            r_out_v <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_res_v <= w_in;
            r_pix_x <= w_in ? w_px[PIXEL_BITS-1:0] : '0;
            r_pix_y <= w_in ? w_py[PIXEL_BITS-1:0] : '0;
            r_depth <= w_in ? r_ms.dmm : '0;
        end
    end

    assign empty = !r_out_v;
    assign o_valid_res = r_res_v;
    assign o_pixel_x = r_pix_x;
    assign o_pixel_y = r_pix_y;
    assign o_depth = r_depth;

endmodule

/* sv/lidar_point_to_pixel_projection.sv */
// Projects lidar points into a camera image, one point per clock when the
// result side keeps popping. A point first passes the transform stages
// (nine 20x20 products, then the camera-frame sums and the reject
// tests), waits in a four-entry queue, then runs through two 30-stage
// pipelined restoring dividers (one quotient bit per stage), one multiply
// stage for the focal length and one rounding and bounds stage. The
// input side stays open as long as the queue has room, even while a result
// waits to be popped; the result side holds a single registered entry.
// Configuration writes are registered; the user must make them only while
// the block holds no point, as the block itself does not enforce this.
module lidar_point_to_pixel_projection #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic signed [19:0]    i_point_x,
    input  logic signed [19:0]    i_point_y,
    input  logic signed [19:0]    i_point_z,
    input  logic                  i_use_roi,
    input  logic [11:0]           i_box_left,
    input  logic [11:0]           i_box_top,
    input  logic [12:0]           i_box_width,
    input  logic [12:0]           i_box_height,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_valid_res,
    output logic [PIXEL_BITS-1:0] o_pixel_x,
    output logic [PIXEL_BITS-1:0] o_pixel_y,
    output logic [19:0]           o_depth
);
    import lpp_pkg::*;

    `include "lidar_point_to_pixel_projection_assert.svh"

    t_cfg           r_cfg;
    logic [MQ_AW:0] r_credit;
    logic           w_accept;
    logic           w_f_valid;
    t_mid           w_f_mid;
    logic           w_mq_empty, w_mq_pop;
    t_mid           w_mq_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT0:  r_cfg.rot0 <= i_cfg_data[62:0];
                CFG_ROT1:  r_cfg.rot1 <= i_cfg_data[62:0];
                CFG_ROT2:  r_cfg.rot2 <= i_cfg_data[62:0];
                CFG_TRANS: r_cfg.translation <= i_cfg_data[62:0];
                CFG_FOCAL: r_cfg.focal <= i_cfg_data;
                CFG_PRINC: r_cfg.principal <= i_cfg_data;
                CFG_IMG_W: r_cfg.img_w <= i_cfg_data[12:0];
                CFG_IMG_H: r_cfg.img_h <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // points in the transform stages or the queue
    assign full = (r_credit == (MQ_AW+1)'(MQ_DEPTH));
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (w_accept && !w_mq_pop) begin
            r_credit <= r_credit + 1'b1;
        end else if (!w_accept && w_mq_pop) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    lpp_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (w_accept),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_use_roi    (i_use_roi),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_valid      (w_f_valid),
        .o_mid        (w_f_mid)
    );

    lpp_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_mid),
        .i_pop   (w_mq_pop),
        .o_empty (w_mq_empty),
        .o_data  (w_mq_data)
    );

    lpp_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mq_empty  (w_mq_empty),
        .i_mq_data   (w_mq_data),
        .o_mq_pop    (w_mq_pop),
        .empty       (empty),
        .pop         (pop),
        .o_valid_res (o_valid_res),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_depth     (o_depth)
    );

    `LPP_ASSERT_NEVER(a_credit_bound, i_clk, i_rst_n,
        r_credit > (MQ_AW+1)'(MQ_DEPTH), "credit count beyond queue depth")
    `LPP_ASSERT_IMPL(a_credit_zero, i_clk, i_rst_n, r_credit == '0, w_mq_empty,
        "queue holds a point with no credit taken")
    `LPP_ASSERT_IMPL(a_reject_zero, i_clk, i_rst_n, !empty && !o_valid_res,
        o_pixel_x == '0 && o_pixel_y == '0 && o_depth == '0,
        "rejected point carries nonzero fields")

endmodule

/* tb/lpp_projection_checker.sv */
`timescale 1ns / 1ps

module lpp_projection_checker #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  push,
    input  logic                  full,
    input  logic signed [19:0]    i_point_x,
    input  logic signed [19:0]    i_point_y,
    input  logic signed [19:0]    i_point_z,
    input  logic                  i_use_roi,
    input  logic [11:0]           i_box_left,
    input  logic [11:0]           i_box_top,
    input  logic [12:0]           i_box_width,
    input  logic [12:0]           i_box_height,
    input  logic                  empty,
    input  logic                  pop,
    input  logic                  i_valid_res,
    input  logic [PIXEL_BITS-1:0] i_pixel_x,
    input  logic [PIXEL_BITS-1:0] i_pixel_y,
    input  logic [19:0]           i_depth,
    output int                    o_errors,
    output int                    o_pending
);
    import lpp_pkg::*;

    typedef struct packed {
        logic                  ok;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] py;
        logic [19:0]           dmm;
    } t_pixel;

    t_cfg   cam_cfg;
    t_pixel expected_pixels[$];

    initial o_errors = 0;
    assign o_pending = expected_pixels.size();

    function automatic longint round_to_pixel(longint f, longint c, longint cam, longint dz);
        longint ratio;
        longint num;
        ratio = (cam * 65536) / dz;
        num = f * ratio + c * 65536 + 64'sd2147483648;
        return num >>> 32;
    endfunction

    function automatic t_pixel project_point(longint x, longint y, longint z, logic roi,
                                             longint bl, longint bt, longint bw, longint bh);
        t_pixel r;
        longint p[3];
        longint cam[3];
        logic [62:0] rows[3];
        longint px, py, lox, loy, hix, hiy, lim, dmm;
        r = '0;
        p[0] = x; p[1] = y; p[2] = z;
        rows[0] = cam_cfg.rot0; rows[1] = cam_cfg.rot1; rows[2] = cam_cfg.rot2;
        if (x <= 0) return r;
        for (int i = 0; i < 3; i++) begin
            cam[i] = longint'($signed(cam_cfg.translation[21*i +: 21])) * 262144;
            for (int j = 0; j < 3; j++)
                cam[i] += p[j] * longint'($signed(rows[j][20*i +: 20]));
        end
        if (cam[2] <= 64'sd1000 * 262144) return r;
        px = round_to_pixel(longint'({32'b0, cam_cfg.focal[31:0]}),
                            longint'({32'b0, cam_cfg.principal[31:0]}), cam[0], cam[2]);
        py = round_to_pixel(longint'({32'b0, cam_cfg.focal[63:32]}),
                            longint'({32'b0, cam_cfg.principal[63:32]}), cam[1], cam[2]);
        if (roi) begin
            lox = bl; loy = bt; hix = bl + bw; hiy = bt + bh;
        end else begin
            lox = 0; loy = 0;
            hix = longint'(cam_cfg.img_w); hiy = longint'(cam_cfg.img_h);
        end
        lim = longint'(1) << PIXEL_BITS;
        if (hix > lim) hix = lim;
        if (hiy > lim) hiy = lim;
        if (!(px >= lox && px < hix && py >= loy && py < hiy)) return r;
        dmm = cam[2] / 262144;
        if (dmm > 1048575) dmm = 1048575;
        r.ok = 1'b1;
        r.px = px[PIXEL_BITS-1:0];
        r.py = py[PIXEL_BITS-1:0];
        r.dmm = dmm[19:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            cam_cfg <= '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROT0:  cam_cfg.rot0 <= i_cfg_data[62:0];
                    CFG_ROT1:  cam_cfg.rot1 <= i_cfg_data[62:0];
                    CFG_ROT2:  cam_cfg.rot2 <= i_cfg_data[62:0];
                    CFG_TRANS: cam_cfg.translation <= i_cfg_data[62:0];
                    CFG_FOCAL: cam_cfg.focal <= i_cfg_data;
                    CFG_PRINC: cam_cfg.principal <= i_cfg_data;
                    CFG_IMG_W: cam_cfg.img_w <= i_cfg_data[12:0];
                    CFG_IMG_H: cam_cfg.img_h <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_valid_res !== want.ok) report_mismatch("valid", i_valid_res, want.ok);
                    if (i_pixel_x !== want.px) report_mismatch("pixel_x", i_pixel_x, want.px);
                    if (i_pixel_y !== want.py) report_mismatch("pixel_y", i_pixel_y, want.py);
                    if (i_depth !== want.dmm) report_mismatch("depth", i_depth, want.dmm);
                end
            end
            if (push && !full)
                expected_pixels.push_back(project_point(i_point_x, i_point_y, i_point_z,
                    i_use_roi, i_box_left, i_box_top, i_box_width, i_box_height));
        end
    end

endmodule

/* tb/lidar_point_to_pixel_projection_tb.sv */
`timescale 1ns / 1ps

module lidar_point_to_pixel_projection_tb;
    import lpp_pkg::*;

    localparam int PIXEL_BITS = 12;
    localparam int RAND_PER_PHASE = 230;
    localparam int NUM_PHASES = 6;
    localparam int TOTAL_ITEMS = RAND_PER_PHASE * NUM_PHASES;
    localparam int STALL_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_idx;
    logic [63:0]           i_cfg_data;
    logic                  push;
    logic                  full;
    logic signed [19:0]    i_point_x, i_point_y, i_point_z;
    logic                  i_use_roi;
    logic [11:0]           i_box_left, i_box_top;
    logic [12:0]           i_box_width, i_box_height;
    logic                  empty;
    logic                  pop;
    logic                  o_valid_res;
    logic [PIXEL_BITS-1:0] o_pixel_x, o_pixel_y;
    logic [19:0]           o_depth;
    int                    errors, pending;
    int                    tx_idle, rx_idle, item_count, stall_cycles;

    lidar_point_to_pixel_projection #(.PIXEL_BITS(PIXEL_BITS)) dut (.*);

    lpp_projection_checker #(.PIXEL_BITS(PIXEL_BITS)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .push, .full,
        .i_point_x, .i_point_y, .i_point_z, .i_use_roi, .i_box_left, .i_box_top,
        .i_box_width, .i_box_height, .empty, .pop, .i_valid_res(o_valid_res),
        .i_pixel_x(o_pixel_x), .i_pixel_y(o_pixel_y), .i_depth(o_depth),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        push = 1'b0; pop = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0; i_use_roi = 1'b0;
        i_box_left = '0; i_box_top = '0; i_box_width = '0; i_box_height = '0;
        tx_idle = 28; rx_idle = 52; item_count = 0;
    end

    always @(posedge i_clk)
        pop <= ($urandom_range(0, 99) >= rx_idle);

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_cfg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(int x, int y, int z, bit roi, int bl, int bt, int bw, int bh);
        if (item_count >= TOTAL_ITEMS * 2 / 3) begin
            tx_idle = 0; rx_idle = 0;
        end else if (item_count >= TOTAL_ITEMS / 3) begin
            tx_idle = 52; rx_idle = 28;
        end
        while ($urandom_range(0, 99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_point_x <= x[19:0]; i_point_y <= y[19:0]; i_point_z <= z[19:0];
        i_use_roi <= roi; i_box_left <= bl[11:0]; i_box_top <= bt[11:0];
        i_box_width <= bw[12:0]; i_box_height <= bh[12:0];
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        item_count++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_point();
        int x, y, z, span;
        if ($urandom_range(0, 3) == 0) begin
            send_point(int'($urandom), int'($urandom), int'($urandom), $urandom_range(0, 1),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 8191), $urandom_range(0, 8191));
        end else begin
            x = $urandom_range(800, ($urandom_range(0, 9) == 0) ? 524287 : 40000);
            span = (x > 262143) ? 262143 : x;
            y = int'($urandom_range(0, 2 * span)) - span;
            z = int'($urandom_range(0, 2 * span)) - span;
            send_point(x, y, z, $urandom_range(0, 1), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4096),
                       $urandom_range(0, 4096));
        end
    endtask

    // camera x = -lidar y, camera y = -lidar z, depth = lidar x
    task automatic standard_cfg(logic [63:0] focal, logic [63:0] princ, int w, int h);
        write_cfg(CFG_ROT0, 64'h40000 << 40);
        write_cfg(CFG_ROT1, 64'hC0000);
        write_cfg(CFG_ROT2, 64'hC0000 << 20);
        write_cfg(CFG_TRANS, '0);
        write_cfg(CFG_FOCAL, focal);
        write_cfg(CFG_PRINC, princ);
        write_cfg(CFG_IMG_W, 64'(w));
        write_cfg(CFG_IMG_H, 64'(h));
    endtask

    initial begin
        logic [63:0] f_std, c_std;
        f_std = {32'd1000 << 16, 32'd1000 << 16};
        c_std = {32'd2048 << 16, 32'd2048 << 16};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: standard_cfg(f_std, c_std, 4096, 4096);
                1: begin
                    standard_cfg({32'd300 << 16, 32'd500 << 16},
                                 {32'd240 << 16, 32'd320 << 16}, 640, 480);
                    write_cfg(CFG_TRANS, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
                end
                2: for (int k = 0; k < 8; k++) write_cfg(t_cfg_idx'(k), '1);
                3: for (int k = 0; k < 8; k++)
                       write_cfg(t_cfg_idx'(k), {$urandom, $urandom});
                4: standard_cfg(f_std, c_std, 0, 4096);
                default: standard_cfg({32'hFFFFFFFF, 32'h0},
                                      {32'h0, 32'hFFFFFFFF}, 4096, 0);
            endcase
            if (ph == 0) begin
                send_point(0, 0, 0, 0, 0, 0, 0, 0);
                send_point(-1, 5, 5, 0, 0, 0, 0, 0);
                send_point(-524288, -524288, -524288, 1, 4095, 4095, 8191, 8191);
                send_point(1000, 0, 0, 0, 0, 0, 0, 0);
                send_point(1001, 0, 0, 0, 0, 0, 0, 0);
                send_point(524287, 524287, 524287, 0, 0, 0, 0, 0);
                send_point(524287, -524288, -524288, 0, 0, 0, 0, 0);
                send_point(2000, 4097, 0, 0, 0, 0, 0, 0);
                send_point(2000, -4097, 0, 0, 0, 0, 0, 0);
                send_point(2000, -4095, -4095, 0, 0, 0, 0, 0);
                send_point(2000, 0, 0, 1, 2048, 2048, 0, 10);
                send_point(2000, 0, 0, 1, 2048, 2048, 10, 0);
                send_point(2000, 0, 0, 1, 2048, 2048, 1, 1);
                send_point(2000, 0, 0, 1, 2049, 2048, 1, 1);
                send_point(2000, -4000, 0, 1, 4095, 0, 4096, 4096);
                send_point(1500, 3000, 3000, 1, 0, 0, 4096, 4096);
                send_point(3000, 1000, -1000, 1, 1500, 2500, 200, 200);
                send_point(524287, 0, 0, 0, 0, 0, 0, 0);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) random_point();
            wait_drained();
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/lpp_pkg.sv
sv/lpp_front.sv
sv/lpp_fifo.sv
sv/lpp_div.sv
sv/lpp_back.sv
sv/lidar_point_to_pixel_projection.sv
tb/lpp_projection_checker.sv
tb/lidar_point_to_pixel_projection_tb.sv
